// ===== sv/spc_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package spc_pkg;
   localparam int MaxVertices = 256;
   localparam int MaxEdges = 1024;
   localparam int VAW = $clog2(MaxVertices);
   localparam int EAW = $clog2(MaxEdges);
   localparam int ECW = EAW + 1;
   localparam int NW = VAW + 1;
   localparam int DW = 48;
   localparam int WW = 30;
   localparam int CW = 30;
   localparam logic [CW-1:0] PathMod = CW'(1000000007);
   localparam logic [DW-1:0] DistInf = '1;

   localparam logic [3:0] OP_IDLE = 4'd0;
   localparam logic [3:0] OP_INIT = 4'd1;
   localparam logic [3:0] OP_SCAN_START = 4'd2;
   localparam logic [3:0] OP_SCAN_RD = 4'd3;
   localparam logic [3:0] OP_SCAN_CMP = 4'd4;
   localparam logic [3:0] OP_PICK = 4'd5;
   localparam logic [3:0] OP_PICK_LATCH = 4'd6;
   localparam logic [3:0] OP_EDGE_RD = 4'd7;
   localparam logic [3:0] OP_EDGE_LATCH = 4'd8;
   localparam logic [3:0] OP_TGT_RD = 4'd9;
   localparam logic [3:0] OP_RELAX = 4'd10;
   localparam logic [3:0] OP_EDGE_NEXT = 4'd11;
   localparam logic [3:0] OP_OUT_RD = 4'd12;
   localparam logic [3:0] OP_OUT = 4'd13;
   localparam logic [3:0] OP_WAIT = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic       side;
   } cmd_type;

   typedef struct packed {
      logic vertex_last;
      logic found;
      logic edge_end;
      logic side0;
      logic side1;
      logic rsp_busy;
   } stat_type;
endpackage

// ===== sv/spc_ctrl.sv =====
// Sequencer for edge loading, vertex scan, edge relaxation and result hand-off.
module spc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spc_pkg::stat_type stat,
   output spc_pkg::cmd_type  cmd,
   output logic              in_ready
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_SCAN_START = 4'd2;
   localparam logic [3:0] S_SCAN_RD = 4'd3;
   localparam logic [3:0] S_SCAN_CMP = 4'd4;
   localparam logic [3:0] S_PICK = 4'd5;
   localparam logic [3:0] S_PICK_LATCH = 4'd6;
   localparam logic [3:0] S_EDGE_CHK = 4'd7;
   localparam logic [3:0] S_EDGE_LATCH = 4'd8;
   localparam logic [3:0] S_SIDE0 = 4'd9;
   localparam logic [3:0] S_RELAX0 = 4'd10;
   localparam logic [3:0] S_SIDE1 = 4'd11;
   localparam logic [3:0] S_RELAX1 = 4'd12;
   localparam logic [3:0] S_EDGE_NEXT = 4'd13;
   localparam logic [3:0] S_OUT_RD = 4'd14;
   localparam logic [3:0] S_OUT = 4'd15;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op = spc_pkg::OP_WAIT;
      cmd.side = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.op = spc_pkg::OP_IDLE;
            if (start) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op = spc_pkg::OP_INIT;
            if (stat.vertex_last) state_in = S_SCAN_START;
         end
         S_SCAN_START: begin
            cmd.op = spc_pkg::OP_SCAN_START;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.op = spc_pkg::OP_SCAN_RD;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.op = spc_pkg::OP_SCAN_CMP;
            state_in = stat.vertex_last ? S_PICK : S_SCAN_RD;
         end
         S_PICK: begin
            if (stat.found) begin
               cmd.op = spc_pkg::OP_PICK;
               state_in = S_PICK_LATCH;
            end else begin
               state_in = S_OUT_RD;
            end
         end
         S_PICK_LATCH: begin
            cmd.op = spc_pkg::OP_PICK_LATCH;
            state_in = S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            cmd.op = spc_pkg::OP_EDGE_RD;
            state_in = stat.edge_end ? S_SCAN_START : S_EDGE_LATCH;
         end
         S_EDGE_LATCH: begin
            cmd.op = spc_pkg::OP_EDGE_LATCH;
            state_in = S_SIDE0;
         end
         S_SIDE0: begin
            if (stat.side0) begin
               cmd.op = spc_pkg::OP_TGT_RD;
               state_in = S_RELAX0;
            end else begin
               state_in = S_SIDE1;
            end
         end
         S_RELAX0: begin
            cmd.op = spc_pkg::OP_RELAX;
            state_in = S_SIDE1;
         end
         S_SIDE1: begin
            cmd.side = 1'b1;
            if (stat.side1) begin
               cmd.op = spc_pkg::OP_TGT_RD;
               state_in = S_RELAX1;
            end else begin
               state_in = S_EDGE_NEXT;
            end
         end
         S_RELAX1: begin
            cmd.op = spc_pkg::OP_RELAX;
            cmd.side = 1'b1;
            state_in = S_EDGE_NEXT;
         end
         S_EDGE_NEXT: begin
            cmd.op = spc_pkg::OP_EDGE_NEXT;
            state_in = S_EDGE_CHK;
         end
         S_OUT_RD: begin
            cmd.op = spc_pkg::OP_OUT_RD;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.op = spc_pkg::OP_OUT;
               state_in = S_IDLE;
            end else begin
               cmd.op = spc_pkg::OP_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== sv/spc_dpath.sv =====
// Edge store, vertex tables, counters and relaxation arithmetic.
module spc_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  spc_pkg::cmd_type          cmd,
   input  logic                      load,
   input  logic                      edge_present,
   input  logic [7:0]                from_vertex,
   input  logic [7:0]                to_vertex,
   input  logic [spc_pkg::WW-1:0]    travel_time,
   input  logic                      csr_we,
   input  logic [8:0]                csr_wdata,
   input  logic                      rsp_tready,
   output spc_pkg::stat_type         stat,
   output logic                      rsp_valid,
   output logic [spc_pkg::CW-1:0]    rsp_count,
   output logic                      rsp_dropped
);
   logic [7:0]               efirst_mem [spc_pkg::MaxEdges];
   logic [7:0]               esecond_mem [spc_pkg::MaxEdges];
   logic [spc_pkg::WW-1:0]   eweight_mem [spc_pkg::MaxEdges];
   logic [spc_pkg::DW-1:0]   dist_mem [spc_pkg::MaxVertices];
   logic [spc_pkg::CW-1:0]   cnt_mem [spc_pkg::MaxVertices];
   logic                     done_mem [spc_pkg::MaxVertices];

   logic [8:0]               vc_ff;
   logic [spc_pkg::ECW-1:0]  stored_ff;
   logic                     over_ff;
   logic [spc_pkg::VAW-1:0]  idx_ff;
   logic [spc_pkg::ECW-1:0]  eidx_ff;
   logic [spc_pkg::DW-1:0]   best_ff, du_ff;
   logic [spc_pkg::CW-1:0]   cu_ff;
   logic [spc_pkg::VAW-1:0]  u_ff;
   logic                     found_ff;
   logic [7:0]               ea_ff, eb_ff, ra_ff, rb_ff;
   logic [spc_pkg::WW-1:0]   ew_ff, rw_ff;
   logic                     s0_ff, s1_ff;
   logic [spc_pkg::DW-1:0]   rdist_ff;
   logic [spc_pkg::CW-1:0]   rcnt_ff;
   logic                     rdone_ff;
   logic                     rsp_valid_ff;
   logic [spc_pkg::CW-1:0]   rsp_count_ff;
   logic                     rsp_dropped_ff;

   logic [spc_pkg::NW-1:0]   nv;
   logic [spc_pkg::VAW-1:0]  vlast;
   logic [spc_pkg::VAW-1:0]  target;
   logic [spc_pkg::VAW-1:0]  rd_addr;
   logic [spc_pkg::DW-1:0]   cand;
   logic [spc_pkg::CW:0]     csum;
   logic [spc_pkg::CW-1:0]   cmod;
   logic                     improve;
   logic [spc_pkg::CW-1:0]   newcnt;
   logic                     in_range;

   always_comb begin
      if (vc_ff == '0) nv = spc_pkg::NW'(1);
      else if (vc_ff > spc_pkg::NW'(spc_pkg::MaxVertices)) nv = spc_pkg::NW'(spc_pkg::MaxVertices);
      else nv = vc_ff;
   end
   assign vlast = spc_pkg::VAW'(nv - spc_pkg::NW'(1));
   assign target = cmd.side ? ra_ff : rb_ff;
   assign cand = du_ff + spc_pkg::DW'(rw_ff);
   assign csum = {1'b0, rcnt_ff} + {1'b0, cu_ff};
   assign cmod = (csum >= {1'b0, spc_pkg::PathMod}) ?
                 spc_pkg::CW'(csum - {1'b0, spc_pkg::PathMod}) : spc_pkg::CW'(csum);
   assign improve = cand < rdist_ff;
   assign newcnt = improve ? cu_ff : cmod;
   assign in_range = ({1'b0, ea_ff} < nv) && ({1'b0, eb_ff} < nv);

   always_comb begin
      case (cmd.op)
         spc_pkg::OP_PICK: rd_addr = u_ff;
         spc_pkg::OP_TGT_RD: rd_addr = target;
         spc_pkg::OP_OUT_RD: rd_addr = vlast;
         default: rd_addr = idx_ff;
      endcase
   end

   assign stat.vertex_last = (idx_ff == vlast);
   assign stat.found = found_ff;
   assign stat.edge_end = (eidx_ff >= stored_ff);
   assign stat.side0 = s0_ff;
   assign stat.side1 = s1_ff;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_dropped = rsp_dropped_ff;

   always_ff @(posedge clock) begin
      if (load && edge_present && (stored_ff < spc_pkg::ECW'(spc_pkg::MaxEdges))) begin
         efirst_mem[stored_ff[spc_pkg::EAW-1:0]] <= from_vertex;
         esecond_mem[stored_ff[spc_pkg::EAW-1:0]] <= to_vertex;
         eweight_mem[stored_ff[spc_pkg::EAW-1:0]] <= travel_time;
      end
      ea_ff <= efirst_mem[eidx_ff[spc_pkg::EAW-1:0]];
      eb_ff <= esecond_mem[eidx_ff[spc_pkg::EAW-1:0]];
      ew_ff <= eweight_mem[eidx_ff[spc_pkg::EAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == spc_pkg::OP_INIT) begin
         dist_mem[idx_ff] <= (idx_ff == '0) ? '0 : spc_pkg::DistInf;
         cnt_mem[idx_ff] <= (idx_ff == '0) ? spc_pkg::CW'(1) : '0;
      end else if ((cmd.op == spc_pkg::OP_RELAX) && (cand <= rdist_ff)) begin
         dist_mem[target] <= cand;
         cnt_mem[target] <= newcnt;
      end
      rdist_ff <= dist_mem[rd_addr];
      rcnt_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == spc_pkg::OP_INIT) begin
         done_mem[idx_ff] <= 1'b0;
      end else if (cmd.op == spc_pkg::OP_PICK) begin
         done_mem[u_ff] <= 1'b1;
      end
      rdone_ff <= done_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         spc_pkg::OP_IDLE: idx_ff <= '0;
         spc_pkg::OP_INIT: idx_ff <= stat.vertex_last ? '0 : idx_ff + 1'b1;
         spc_pkg::OP_SCAN_START: begin
            idx_ff <= '0;
            best_ff <= spc_pkg::DistInf;
            found_ff <= 1'b0;
         end
         spc_pkg::OP_SCAN_CMP: begin
            if (!rdone_ff && (rdist_ff < best_ff)) begin
               best_ff <= rdist_ff;
               u_ff <= idx_ff;
               found_ff <= 1'b1;
            end
            idx_ff <= stat.vertex_last ? '0 : idx_ff + 1'b1;
         end
         spc_pkg::OP_PICK_LATCH: begin
            du_ff <= rdist_ff;
            cu_ff <= rcnt_ff;
            eidx_ff <= '0;
         end
         spc_pkg::OP_EDGE_LATCH: begin
            ra_ff <= ea_ff;
            rb_ff <= eb_ff;
            rw_ff <= ew_ff;
            s0_ff <= in_range && (ea_ff == u_ff);
            s1_ff <= in_range && (eb_ff == u_ff);
         end
         spc_pkg::OP_RELAX: begin
            if ((cand <= rdist_ff) && (target == u_ff)) cu_ff <= newcnt;
         end
         spc_pkg::OP_EDGE_NEXT: eidx_ff <= eidx_ff + 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 9'd1;
         stored_ff <= '0;
         over_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) vc_ff <= csr_wdata;
         if (load && edge_present) begin
            if (stored_ff < spc_pkg::ECW'(spc_pkg::MaxEdges)) stored_ff <= stored_ff + 1'b1;
            else over_ff <= 1'b1;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (cmd.op == spc_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
            stored_ff <= '0;
            over_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == spc_pkg::OP_OUT) begin
         rsp_count_ff <= rcnt_ff;
         rsp_dropped_ff <= over_ff;
      end
   end
endmodule

// ===== sv/shortest_path_count.sv =====
// Top level: edge loading and shortest-path counting from vertex 0 to vertex_count-1.
// Loading: one edge beat per idle cycle into a 1024-entry store; non-last beats give no result.
// Last beat: an init pass, then per round a scan of all vertices, a pick and relaxation of
// every stored edge (single-port vertex tables); a final round finds nothing, then output.
// Throughput: one graph per computation; rsp is registered and waits for rsp_tready.
// Reset clears control, counters and vertex_count to 1; tables need no clearing pass.
module shortest_path_count (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // from_vertex[7:0], to_vertex[15:8], travel_time[45:16], zero
   input  logic        req_tuser,  // edge_present
   input  logic        req_tlast,  // last_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // path_count[29:0], edges_dropped[30], zero
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);
   spc_pkg::cmd_type  cmd;
   spc_pkg::stat_type stat;
   logic              accept;
   logic [29:0]       count;
   logic              dropped;

   assign accept = req_tvalid && req_tready;

   spc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && req_tlast),
      .stat     (stat),
      .cmd      (cmd),
      .in_ready (req_tready)
   );

   spc_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .load         (accept),
      .edge_present (req_tuser),
      .from_vertex  (req_tdata[7:0]),
      .to_vertex    (req_tdata[15:8]),
      .travel_time  (req_tdata[45:16]),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .stat         (stat),
      .rsp_valid    (rsp_tvalid),
      .rsp_count    (count),
      .rsp_dropped  (dropped)
   );

   assign rsp_tdata = {1'b0, dropped, count};
endmodule

// ===== test/tb_shortest_path_count.sv =====
// Testbench for shortest_path_count: graph beats with a shortest-path-count predictor.
module tb_shortest_path_count;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [8:0]  csr_wdata = '0;

   typedef struct {
      logic [29:0] path_count;
      logic        dropped;
   } count_result_type;

   logic [8:0]       vertex_count_q = 9'd1;
   logic [7:0]       edge_a_q[$];
   logic [7:0]       edge_b_q[$];
   logic [29:0]      edge_w_q[$];
   logic             overflow_q = 1'b0;
   count_result_type pending_counts[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int errors = 0;
   int beats_sent = 0;
   int graphs_checked = 0;
   int idle_cycles = 0;

   shortest_path_count i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [29:0] count_paths();
      int n;
      int u;
      longint unsigned dist_v[spc_pkg::MaxVertices];
      logic [29:0] ways[spc_pkg::MaxVertices];
      bit finished[spc_pkg::MaxVertices];
      longint unsigned best;
      longint unsigned cand;
      int a;
      int b;
      int s;
      int t;
      n = (vertex_count_q == 0) ? 1 :
          (vertex_count_q > spc_pkg::MaxVertices) ? spc_pkg::MaxVertices : vertex_count_q;
      for (int i = 0; i < n; i++) begin
         dist_v[i] = 64'(spc_pkg::DistInf);
         ways[i] = '0;
         finished[i] = 1'b0;
      end
      dist_v[0] = 0;
      ways[0] = 30'd1;
      for (int r = 0; r < n; r++) begin
         u = n;
         best = 64'(spc_pkg::DistInf);
         for (int i = 0; i < n; i++) begin
            if (!finished[i] && dist_v[i] < best) begin
               best = dist_v[i];
               u = i;
            end
         end
         if (u >= n) break;
         finished[u] = 1'b1;
         for (int e = 0; e < edge_a_q.size(); e++) begin
            a = edge_a_q[e];
            b = edge_b_q[e];
            if (a >= n || b >= n) continue;
            for (int side = 0; side < 2; side++) begin
               s = side ? b : a;
               t = side ? a : b;
               if (s != u) continue;
               cand = dist_v[u] + 64'(edge_w_q[e]);
               if (cand < dist_v[t]) begin
                  dist_v[t] = cand;
                  ways[t] = ways[u];
               end else if (cand == dist_v[t]) begin
                  ways[t] = 30'((64'(ways[t]) + 64'(ways[u])) % 64'(spc_pkg::PathMod));
               end
            end
         end
      end
      return ways[n-1];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_edge(input bit present, input logic [7:0] a, input logic [7:0] b,
                            input logic [29:0] w, input bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, w, b, a};
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (present) begin
         if (edge_a_q.size() < spc_pkg::MaxEdges) begin
            edge_a_q.push_back(a);
            edge_b_q.push_back(b);
            edge_w_q.push_back(w);
         end else begin
            overflow_q = 1'b1;
         end
      end
      if (last) begin
         pending_counts.push_back('{count_paths(), overflow_q});
         edge_a_q.delete();
         edge_b_q.delete();
         edge_w_q.delete();
         overflow_q = 1'b0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [8:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      vertex_count_q = value;
   endtask

   task automatic send_layers(input int width, input int layers);
      logic [29:0] w;
      int base;
      int dest;
      dest = width * layers + 1;
      write_vertex_count(9'(dest + 1));
      w = 30'($urandom_range(0, 5));
      for (int j = 0; j < width; j++) send_edge(1'b1, 8'd0, 8'(1 + j), w, 1'b0);
      for (int k = 0; k < layers - 1; k++) begin
         w = 30'($urandom_range(0, 5));
         base = 1 + k * width;
         for (int i = 0; i < width; i++)
            for (int j = 0; j < width; j++)
               send_edge(1'b1, 8'(base + i), 8'(base + width + j), w, 1'b0);
      end
      w = 30'($urandom_range(0, 5));
      base = 1 + (layers - 1) * width;
      for (int j = 0; j < width; j++)
         send_edge(1'b1, 8'(base + j), 8'(dest), w, j == width - 1);
   endtask

   task automatic send_random_graph();
      int n;
      int edges;
      logic [7:0] a;
      logic [7:0] b;
      logic [29:0] w;
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 9))
            0: write_vertex_count(9'($urandom));
            1: write_vertex_count(9'($urandom_range(17, 256)));
            default: write_vertex_count(9'($urandom_range(1, 12)));
         endcase
      end
      if ($urandom_range(0, 19) == 0) begin
         send_layers($urandom_range(2, 4), $urandom_range(2, 5));
         return;
      end
      n = (vertex_count_q == 0) ? 1 :
          (vertex_count_q > spc_pkg::MaxVertices) ? spc_pkg::MaxVertices : vertex_count_q;
      edges = $urandom_range(0, 12);
      for (int e = 0; e <= edges; e++) begin
         if ($urandom_range(0, 9) == 0) begin
            a = 8'($urandom);
            b = 8'($urandom);
         end else begin
            a = 8'($urandom_range(0, n - 1));
            b = 8'($urandom_range(0, n - 1));
         end
         w = ($urandom_range(0, 4) == 0) ? 30'($urandom) : 30'($urandom_range(0, 3));
         send_edge((e == edges) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) != 0),
                   a, b, w, e == edges);
      end
   endtask

   task automatic test_directed();
      write_vertex_count(9'd1);
      send_edge(1'b0, 8'd0, 8'd0, 30'd0, 1'b1);
      write_vertex_count(9'd0);
      send_edge(1'b1, 8'd255, 8'd255, 30'h3FFFFFFF, 1'b1);
      write_vertex_count(9'd2);
      send_edge(1'b1, 8'd0, 8'd1, 30'h3FFFFFFF, 1'b0);
      send_edge(1'b1, 8'd1, 8'd0, 30'h3FFFFFFF, 1'b1);
      write_vertex_count(9'd4);
      send_edge(1'b1, 8'd0, 8'd1, 30'd5, 1'b0);
      send_edge(1'b1, 8'd0, 8'd2, 30'd5, 1'b0);
      send_edge(1'b1, 8'd1, 8'd3, 30'd0, 1'b0);
      send_edge(1'b1, 8'd2, 8'd3, 30'd0, 1'b0);
      send_edge(1'b1, 8'd3, 8'd3, 30'd7, 1'b0);
      send_edge(1'b1, 8'd0, 8'd200, 30'd1, 1'b0);
      send_edge(1'b0, 8'd0, 8'd3, 30'd1, 1'b0);
      send_edge(1'b1, 8'd1, 8'd2, 30'd0, 1'b1);
      write_vertex_count(9'd3);
      send_edge(1'b1, 8'd0, 8'd1, 30'd1, 1'b1);
      write_vertex_count(9'd256);
      send_edge(1'b1, 8'd255, 8'd0, 30'd0, 1'b1);
      write_vertex_count(9'd511);
      send_edge(1'b1, 8'd0, 8'd255, 30'd1, 1'b1);
   endtask

   task automatic test_overflow();
      write_vertex_count(9'd2);
      for (int e = 0; e < spc_pkg::MaxEdges + 2; e++)
         send_edge(1'b1, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                   30'($urandom_range(0, 2)), e == spc_pkg::MaxEdges + 1);
      send_edge(1'b1, 8'd0, 8'd1, 30'd9, 1'b1);
   endtask

   task automatic test_count_wrap();
      send_layers(2, 31);
   endtask

   task automatic test_backpressure();
      write_vertex_count(9'd5);
      hold_request = 400;
      repeat (6) send_random_graph();
   endtask

   task automatic test_random(input int beats);
      int stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) send_random_graph();
   endtask

   always @(posedge clock) begin
      count_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            want = pending_counts.pop_front();
            graphs_checked++;
            if (rsp_tdata[29:0] != want.path_count)
               report_mismatch("path_count", rsp_tdata[29:0], want.path_count);
            if (rsp_tdata[30] != want.dropped)
               report_mismatch("edges_dropped", rsp_tdata[30], want.dropped);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("timeout after %0d cycles without a beat", IdleLimit);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_count_wrap();
      send_idle_pct = 37;
      recv_idle_pct = 54;
      test_backpressure();
      test_random(20);
      send_idle_pct = 54;
      recv_idle_pct = 37;
      test_random(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(20);
      write_vertex_count(9'd1);
      repeat (50) @(posedge clock);
      $display("covered %0d edge beats and %0d graph results, incl. store overflow,",
               beats_sent, graphs_checked);
      $display("count wrap, out-of-range vertices, zero weights and output stalls");
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
